### src/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    // Queue geometry and stored field widths.
    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int TAG_BITS      = 32;

    // Fixed widths of the words on the channels.
    localparam int PRIO_FIELD_W = 8;
    localparam int TAG_FIELD_W  = 32;
    localparam int OCC_FIELD_W  = 5;

    // Entry count must hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [PRIORITY_BITS-1:0] t_prio;
    typedef logic [TAG_BITS-1:0]      t_tag;
    typedef logic [CNT_W-1:0]         t_count;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_REMOVED  = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                     operation;
        logic [PRIO_FIELD_W-1:0] entry_priority;
        logic [TAG_FIELD_W-1:0]  entry_tag;
    } t_req;

    typedef struct packed {
        t_status                 status;
        logic [PRIO_FIELD_W-1:0] served_priority;
        logic [TAG_FIELD_W-1:0]  served_tag;
        logic [OCC_FIELD_W-1:0]  occupancy;
    } t_rsp;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

### src/spq_if.sv
`timescale 1ns / 1ps

interface spq_req_if;
    import spq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/spq_ctrl.sv
`timescale 1ns / 1ps

module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  spq_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The update waits in EXEC until the result register can take the new word.
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### src/spq_datapath.sv
`timescale 1ns / 1ps

module spq_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spq_pkg::t_dp_cmd i_cmd,
    output spq_pkg::t_dp_sts o_sts,
    input  spq_pkg::t_req    i_req_data,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output spq_pkg::t_rsp    o_rsp_data
);
    import spq_pkg::*;

    // Latched request.
    t_op    r_op;
    t_prio  r_prio;
    t_tag   r_tag;

    // Sorted slots, head at index 0.
    t_prio  r_slot_prio [DEPTH];
    t_tag   r_slot_tag  [DEPTH];
    t_prio  n_slot_prio [DEPTH];
    t_tag   n_slot_tag  [DEPTH];
    t_count r_count;
    t_count n_count;

    // Result register.
    logic   r_out_valid;
    t_rsp   r_out;
    t_rsp   n_out;

    logic [DEPTH-1:0] keep;
    logic             is_full;
    logic             is_empty;
    logic             do_write;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_req_data.operation;
            r_prio <= t_prio'(i_req_data.entry_priority);
            r_tag  <= t_tag'(i_req_data.entry_tag);
        end
    end

    // An entry stays in place while it is stored and its priority is not lower
    // than the new one; the slots are sorted, so these bits form a prefix.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            keep[i] = (CNT_W'(i) < r_count) && (r_slot_prio[i] >= r_prio);
        end
    end

    always_comb begin
        n_slot_prio = r_slot_prio;
        n_slot_tag  = r_slot_tag;
        n_count     = r_count;
        n_out       = '0;
        do_write    = 1'b0;
        if (r_op == OP_INSERT) begin
            if (is_full) begin
                n_out.status = STATUS_FULL;
            end else begin
                do_write     = 1'b1;
                n_count      = r_count + 1'b1;
                n_out.status = STATUS_INSERTED;
                if (!keep[0]) begin
                    n_slot_prio[0] = r_prio;
                    n_slot_tag[0]  = r_tag;
                end
                for (int i = 1; i < DEPTH; i++) begin
                    if (!keep[i]) begin
                        if (keep[i-1]) begin
                            n_slot_prio[i] = r_prio;
                            n_slot_tag[i]  = r_tag;
                        end else begin
                            n_slot_prio[i] = r_slot_prio[i-1];
                            n_slot_tag[i]  = r_slot_tag[i-1];
                        end
                    end
                end
            end
        end else begin
            if (is_empty) begin
                n_out.status = STATUS_EMPTY;
            end else begin
                do_write              = 1'b1;
                n_count               = r_count - 1'b1;
                n_out.status          = STATUS_REMOVED;
                n_out.served_priority = PRIO_FIELD_W'(r_slot_prio[0]);
                n_out.served_tag      = TAG_FIELD_W'(r_slot_tag[0]);
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_slot_prio[i] = r_slot_prio[i+1];
                    n_slot_tag[i]  = r_slot_tag[i+1];
                end
            end
        end
        n_out.occupancy = OCC_FIELD_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            r_slot_prio <= n_slot_prio;
            r_slot_tag  <= n_slot_tag;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp_data     = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("update without a result word");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_INSERT && !is_full)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the queue");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (r_slot_prio[0] >= r_slot_prio[1]))
        else $error("head slots out of order");
`endif

endmodule

### src/stable_priority_queue.sv
`timescale 1ns / 1ps

// Channel  Direction  Word                                         Handshake
// i_req    in         operation, entry_priority, entry_tag         valid / ready
// o_rsp    out        status, served_priority, served_tag, occ.    valid / ready
//
// A request word is accepted first; then, for an insert, all slots compare
// against the new priority in parallel, and the slots shift by one place.
// A result word waits in an output register, so the next request is accepted
// while it is still pending; the update then holds until that word is taken.
// Reset (i_rst_n, synchronous, active low) empties the queue and drops any
// pending result; slot contents are left as they are.
// A back-pressured output stalls the update stage, never the queue contents.

module stable_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spq_req_if.sink           i_req,
    spq_rsp_if.source         o_rsp
);
    import spq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // The controller sequences accept and update; it never touches payload.
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the sorted slots, the entry count and the result word.
    spq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req_data  (i_req.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_data  (o_rsp.data)
    );

    assign i_req.ready = w_in_ready;

endmodule

### dv/tb_stable_priority_queue.sv
`timescale 1ns / 1ps

// Self-checking bench for the stable priority queue. Request words go in on
// one channel, one result word comes back for each, in order. A shadow copy
// of the queue inside the bench predicts every result word at the moment its
// request word is accepted. A separate process compares the returned words
// field by field against the oldest prediction.
module tb_stable_priority_queue;
    import spq_pkg::*;

    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES  = 240;
    // Quiet cycles allowed after the last result word before the verdict.
    localparam int SETTLE_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    stable_priority_queue u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 12 ns period: 6 ns high, 6 ns low.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the queue, sorted with the head in slot 0.
    t_prio shadow_prio [DEPTH];
    t_tag  shadow_tag  [DEPTH];
    int    shadow_count;

    // Result words predicted but not yet returned, oldest first.
    t_rsp awaited_rsp [$];

    int fail_count;
    int words_sent;
    int n_stored;
    int n_served;
    int n_empty;
    int n_refused;
    int deepest;

    // Idling controls. The sender side is used only by the main process; the
    // receiver side and the hold-off request are handed over with
    // nonblocking writes so that the receiver process sees them race-free.
    bit   tx_idle;
    logic rx_idle = 1'b0;
    int   hold_requests = 0;

    // Applies one request to the shadow queue and returns the result word it
    // must produce. An insert goes behind every entry of equal or higher
    // priority, which keeps equal priorities in arrival order.
    function automatic t_rsp apply_queue_op(t_req w);
        t_rsp  r;
        int    pos;
        t_prio p;
        r = '0;
        p = t_prio'(w.entry_priority);
        if (w.operation == OP_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = STATUS_FULL;
                n_refused++;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= p)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_prio[i] = shadow_prio[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                end
                shadow_prio[pos] = p;
                shadow_tag[pos]  = t_tag'(w.entry_tag);
                shadow_count++;
                r.status = STATUS_INSERTED;
                n_stored++;
            end
        end else if (shadow_count == 0) begin
            r.status = STATUS_EMPTY;
            n_empty++;
        end else begin
            r.status          = STATUS_REMOVED;
            r.served_priority = PRIO_FIELD_W'(shadow_prio[0]);
            r.served_tag      = TAG_FIELD_W'(shadow_tag[0]);
            for (int i = 1; i < shadow_count; i++) begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_tag[i-1]  = shadow_tag[i];
            end
            shadow_count--;
            n_served++;
        end
        r.occupancy = OCC_FIELD_W'(shadow_count);
        if (shadow_count > deepest)
            deepest = shadow_count;
        return r;
    endfunction

    // Offers one request word and holds it until the queue accepts it. The
    // prediction is made at the accepting edge, so the expected words stay in
    // the order in which the block must return them. The valid line is only
    // ever written once per edge: an idle gap lowers it at the edge after an
    // acceptance and raises it again at a later edge.
    task automatic send_word(input t_op op, input logic [7:0] prio,
                             input logic [31:0] tag);
        t_req w;
        w.operation      = op;
        w.entry_priority = prio;
        w.entry_tag      = tag;
        if (tx_idle && $urandom_range(99) < 19) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        awaited_rsp.push_back(apply_queue_op(w));
        words_sent++;
    endtask

    // Stops offering words and waits until every predicted result has come.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // Priorities lean on the extremes and on a narrow band, so that ties,
    // which exercise arrival order, come up often.
    function automatic logic [7:0] pick_priority(input logic [7:0] band);
        int roll;
        roll = $urandom_range(99);
        if (roll < 12)
            return 8'h00;
        if (roll < 24)
            return 8'hFF;
        if (roll < 60)
            return band + 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // Removes on an empty queue, then a handful of inserts at the extremes of
    // priority and tag, two pairs of them with equal priority, drained in full.
    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
        send_word(OP_REMOVE, 8'h00, 32'h0000_0000);
        send_word(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 8'h00, 32'h0000_0000);
        send_word(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
        send_word(OP_INSERT, 8'h80, 32'h5A5A_A5A5);
        send_word(OP_INSERT, 8'hFF, 32'hA5A5_5A5A);
        send_word(OP_INSERT, 8'h00, 32'h8000_0001);
        send_word(OP_INSERT, 8'h7F, 32'h7FFF_FFFE);
        repeat (6)
            send_word(OP_REMOVE, 8'($urandom()), $urandom());
        send_word(OP_REMOVE, 8'h00, 32'h0000_0000);
        // Insert of a single entry, then two removes, the second on an empty queue.
        send_word(OP_INSERT, 8'h01, 32'h0000_0001);
        send_word(OP_REMOVE, 8'h00, 32'h0000_0000);
        send_word(OP_REMOVE, 8'h00, 32'h0000_0000);
    endtask

    // Fills the queue to DEPTH, pushes inserts against the full queue, then
    // drains it to empty and one step beyond.
    task automatic test_fill_and_overflow(input bit with_idle);
        logic [7:0] band;
        tx_idle = with_idle;
        rx_idle <= with_idle;
        band = 8'($urandom());
        repeat (DEPTH)
            send_word(OP_INSERT, pick_priority(band), $urandom());
        repeat ($urandom_range(2, 4))
            send_word(OP_INSERT, pick_priority(band), $urandom());
        repeat (DEPTH + 1)
            send_word(OP_REMOVE, 8'($urandom()), $urandom());
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the output register fills and the input stalls.
    task automatic test_backpressure();
        logic [7:0] band;
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        band = 8'($urandom());
        hold_requests <= hold_requests + 1;
        repeat (30)
            send_word(($urandom_range(99) < 70) ? OP_INSERT : OP_REMOVE,
                      pick_priority(band), $urandom());
        // Sender pauses here until every outstanding word has come back.
        wait_drained();
        repeat (shadow_count + 1)
            send_word(OP_REMOVE, 8'($urandom()), $urandom());
    endtask

    // Bursts with a random bias towards inserts or removes, so that the
    // occupancy wanders over its whole range, full and empty included. A
    // small share of bursts is plain noise with an even split.
    task automatic test_random_mix(input int n_words, input bit with_idle);
        int         left;
        int         burst;
        int         bias;
        logic [7:0] band;
        tx_idle = with_idle;
        rx_idle <= with_idle;
        left = n_words;
        while (left > 0) begin
            burst = $urandom_range(8, 48);
            if (burst > left)
                burst = left;
            case ($urandom_range(0, 4))
                0, 1: bias = 80;
                2, 3: bias = 25;
                default: bias = 50;
            endcase
            band = 8'($urandom());
            repeat (burst)
                send_word(($urandom_range(99) < bias) ? OP_INSERT : OP_REMOVE,
                          pick_priority(band), $urandom());
            left -= burst;
        end
    endtask

    // Receiver: drives ready once per edge. A hold-off request starts a long
    // run of low ready, counted here in cycles; otherwise ready drops at
    // random while receiver idling is enabled.
    initial begin : rsp_acceptor
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES - 1;
                rsp_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (rx_idle && $urandom_range(99) < 19) begin
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Checker: every accepted result word is matched against the oldest
    // prediction. Values are sampled as they stood before the edge.
    initial begin : rsp_checker
        t_rsp got;
        t_rsp want;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got = rsp_if.data;
                if (awaited_rsp.size() == 0) begin
                    $error("result word with none expected: status %0d", got.status);
                    fail_count++;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.served_priority !== want.served_priority) begin
                        $error("served_priority: expected %0d, got %0d",
                               want.served_priority, got.served_priority);
                        fail_count++;
                    end
                    if (got.served_tag !== want.served_tag) begin
                        $error("served_tag: expected %h, got %h",
                               want.served_tag, got.served_tag);
                        fail_count++;
                    end
                    if (got.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, got.occupancy);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then the verdict.
    initial begin
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        tx_idle      = 1'b0;
        shadow_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_overflow(1'b1);
        test_backpressure();
        test_random_mix(1100, 1'b1);
        test_fill_and_overflow(1'b0);
        // A long stretch with no idling on either side.
        test_random_mix(320, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d request words: %0d stored, %0d served, %0d on empty, %0d refused.",
                 words_sent, n_stored, n_served, n_empty, n_refused);
        $display("Deepest occupancy reached: %0d of %0d slots.", deepest, DEPTH);
        if (fail_count == 0) begin
            $display("tb_stable_priority_queue: done, clean");
        end else begin
            $display("tb_stable_priority_queue: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this sequence.
    initial begin
        #4_000_000;
        $display("tb_stable_priority_queue: done, errors");
        $finish;
    end

endmodule

### stable_priority_queue.f
src/spq_pkg.sv
src/spq_if.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/stable_priority_queue.sv
dv/tb_stable_priority_queue.sv
